### rtl/core/sts_pkg.sv
// Package for the SQL token scanner: token codes, scan modes, result type
// and the keyword lookup function. No dependencies.
package sts_pkg;

    localparam int POSITION_BITS = 16;
    localparam int KEYWORD_COUNT = 40;
    localparam int KW_CHARS      = 8;
    localparam int MAX_RESULTS   = 3;

    typedef logic [POSITION_BITS-1:0] t_pos;

    typedef enum logic [3:0] {
        M_IDLE, M_IDENT, M_NUMBER, M_STRING, M_ESCAPE,
        M_HOLD, M_LINE, M_BLOCK, M_STAR
    } t_mode;

    localparam logic [5:0] K_END = 6'd0, K_IDENT = 6'd1, K_INT = 6'd2, K_FLOAT = 6'd3,
        K_STRING = 6'd4, K_EQ = 6'd5, K_NE = 6'd6, K_LT = 6'd7, K_LE = 6'd8,
        K_GT = 6'd9, K_GE = 6'd10, K_SEMI = 6'd11, K_COMMA = 6'd12,
        K_LPAREN = 6'd13, K_RPAREN = 6'd14, K_MUL = 6'd15, K_DOT = 6'd16,
        K_UNKNOWN = 6'd17, K_KEYWORD0 = 6'd18, K_NOT = 6'd33;

    typedef struct packed {
        logic [5:0]  kind;
        logic [15:0] offset;
        logic [15:0] length;
        logic [15:0] line;
        logic [15:0] column;
        logic        fin;
    } t_token;

    typedef logic [8*KW_CHARS-1:0] t_word;

    localparam t_word KW_ROM [KEYWORD_COUNT] = '{
        64'h0000_5345_4C45_4354, 64'h0000_494E_5345_5254, 64'h0000_5550_4441_5445,
        64'h0000_4445_4C45_5445, 64'h0000_4352_4541_5445, 64'h0000_0000_4452_4F50,
        64'h0000_0054_4142_4C45, 64'h0000_0049_4E44_4558, 64'h0000_0000_4652_4F4D,
        64'h0000_0057_4845_5245, 64'h0000_0000_0053_4554, 64'h0000_5641_4C55_4553,
        64'h0000_0000_494E_544F, 64'h0000_0000_0041_4E44, 64'h0000_0000_0000_4F52,
        64'h0000_0000_004E_4F54, 64'h0000_0000_4C49_4B45, 64'h0000_0000_0000_494E,
        64'h0042_4554_5745_454E, 64'h0000_0000_0000_4953, 64'h0000_0000_4E55_4C4C,
        64'h0000_004F_5244_4552, 64'h0000_0000_0000_4259, 64'h0000_0047_524F_5550,
        64'h0000_4841_5649_4E47, 64'h0000_004C_494D_4954, 64'h0000_4F46_4653_4554,
        64'h0000_0000_4A4F_494E, 64'h0000_0049_4E4E_4552, 64'h0000_0000_4C45_4654,
        64'h0000_0052_4947_4854, 64'h0000_004F_5554_4552, 64'h0000_0000_0000_4F4E,
        64'h0000_0000_0000_4153, 64'h4449_5354_494E_4354, 64'h0050_5249_4D41_5259,
        64'h0000_0000_004B_4559, 64'h0000_554E_4951_5545, 64'h0000_0000_0041_5343,
        64'h0000_0000_4445_5343
    };

    // Map a packed upper-case word to its keyword code, or identifier.
    function automatic logic [5:0] kw_lookup(input t_word w);
        logic [5:0] k;
        k = K_IDENT;
        for (int i = KEYWORD_COUNT - 1; i >= 0; i--) begin
            if (KW_ROM[i] == w) k = K_KEYWORD0 + 6'(i);
        end
        return k;
    endfunction

endpackage

### rtl/core/sql_token_scanner.sv
// Top level of the SQL token scanner: input register, lexer step and a
// small token queue on the output. Depends on sts_pkg and sts_lexer.
//
// One source byte is taken per cycle while s_axis_tready is high. Each
// byte runs through the lexer in the cycle after it is registered and
// drops up to three tokens into an eight-entry queue; the output side pops
// one token per cycle while m_axis_tready is high. Input is accepted
// whenever the queue has room for two bytes' worth of tokens (the
// registered byte's and the one being accepted), so sustained rate is one
// byte per cycle while tokens are drained at least as fast as they appear.
// A byte's first token passes the input register and queue before output.
module sql_token_scanner (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] source_byte
    input  logic        s_axis_tlast,   // end_of_source
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // kind[5:0] offset[21:6] length[37:22]
                                        // line[53:38] column[69:54], zero pad
    output logic        m_axis_tlast    // final_result
);
    import sts_pkg::*;

    localparam int QD = 8;
    localparam int QW = $clog2(QD);

    logic        r_in_v;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic [1:0]  lx_count;
    t_token      lx_tok [MAX_RESULTS];
    t_token      r_q [QD];
    logic [QW-1:0] r_rd, r_wr;
    logic [QW:0] r_fill, n_fill;
    logic        pop;

    sts_lexer u_lexer (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(r_in_v),
        .i_byte(r_in_byte), .i_last(r_in_last),
        .o_count(lx_count), .o_tok(lx_tok)
    );

    // Room for the registered byte's tokens plus the next one's.
    assign s_axis_tready = r_fill <= (QW+1)'(QD - 2*MAX_RESULTS);
    assign pop = m_axis_tvalid && m_axis_tready;
    assign m_axis_tvalid = r_fill != '0;
    assign m_axis_tdata = {2'b00, r_q[r_rd].column, r_q[r_rd].line, r_q[r_rd].length,
                           r_q[r_rd].offset, r_q[r_rd].kind};
    assign m_axis_tlast = r_q[r_rd].fin;

    always_comb begin
        n_fill = r_fill + (r_in_v ? (QW+1)'(lx_count) : '0) - (pop ? (QW+1)'(1) : '0);
    end

    // Register the input request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_in_v <= 1'b0;
        else r_in_v <= s_axis_tvalid && s_axis_tready;
        r_in_byte <= s_axis_tdata;
        r_in_last <= s_axis_tlast;
    end

    // Push lexer tokens, pop delivered ones.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd <= '0; r_wr <= '0; r_fill <= '0;
        end else begin
            if (r_in_v) begin
                for (int i = 0; i < MAX_RESULTS; i++) begin
                    if (2'(i) < lx_count) r_q[r_wr + QW'(i)] <= lx_tok[i];
                end
                r_wr <= r_wr + QW'(lx_count);
            end
            if (pop) r_rd <= r_rd + 1'b1;
            r_fill <= n_fill;
        end
    end

endmodule

### rtl/core/sts_lexer.sv
// Per-byte lexer step: state registers and the combinational update that
// yields up to three tokens per byte. Depends on sts_pkg.
module sts_lexer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic [7:0]                  i_byte,
    input  logic                        i_last,
    output logic [1:0]                  o_count,
    output sts_pkg::t_token             o_tok [sts_pkg::MAX_RESULTS]
);
    import sts_pkg::*;

    localparam t_pos POS_MAX = '1;

    t_mode r_mode, n_mode;
    logic [7:0] r_held, n_held;
    t_word r_word, n_word;
    logic r_long, n_long, r_dot, n_dot, r_dq, n_dq;
    t_pos r_soff, r_sline, r_scol, r_off, r_line, r_col;
    t_pos n_soff, n_sline, n_scol, n_off, n_line, n_col;

    // Clip a position to the 16-bit output field.
    function automatic logic [15:0] clip(input t_pos v);
        if (POSITION_BITS > 16 && (v >> 16) != '0) return 16'hFFFF;
        return 16'(v);
    endfunction

    function automatic t_pos sinc(input t_pos v);
        return (v == POS_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic [5:0] held_kind(input logic [7:0] h);
        case (h)
            8'h3D:   return K_EQ;
            8'h21:   return K_NOT;
            8'h3C:   return K_LT;
            8'h3E:   return K_GT;
            default: return K_UNKNOWN;
        endcase
    endfunction

    logic c_alpha, c_digit, c_ws;
    logic [7:0] c_up;
    logic [5:0] word_kind;
    t_pos open_len;

    always_comb begin
        c_alpha = (i_byte >= 8'h61 && i_byte <= 8'h7A) ||
                  (i_byte >= 8'h41 && i_byte <= 8'h5A) || i_byte == 8'h5F;
        c_digit = i_byte >= 8'h30 && i_byte <= 8'h39;
        c_ws    = i_byte == 8'h20 || i_byte == 8'h09 || i_byte == 8'h0D || i_byte == 8'h0A;
        c_up    = (i_byte >= 8'h61 && i_byte <= 8'h7A) ? i_byte - 8'd32 : i_byte;
        word_kind = r_long ? K_IDENT : kw_lookup(r_word);
        open_len  = r_off - r_soff;
    end

    // One byte: close any open token, then treat the byte from idle if needed.
    always_comb begin
        logic again, start_after;
        logic [5:0] k;
        logic [1:0] n;
        n_mode = r_mode; n_held = r_held; n_word = r_word; n_long = r_long;
        n_dot = r_dot; n_dq = r_dq;
        n_soff = r_soff; n_sline = r_sline; n_scol = r_scol;
        again = 1'b0; start_after = 1'b0; n = 2'd0; k = K_UNKNOWN;
        for (int i = 0; i < MAX_RESULTS; i++) o_tok[i] = '0;

        unique case (r_mode)
            M_IDENT: begin
                if (c_alpha || c_digit) begin
                    if (r_word[63:56] != 8'd0) n_long = 1'b1;
                    else n_word = {r_word[55:0], c_up};
                end else begin
                    o_tok[0] = '{word_kind, clip(r_soff), clip(open_len), clip(r_sline),
                                 clip(r_scol), 1'b0};
                    n = 2'd1; again = 1'b1;
                end
            end
            M_NUMBER: begin
                if (c_digit) begin
                end else if (i_byte == 8'h2E && !r_dot) begin
                    n_dot = 1'b1;
                end else begin
                    o_tok[0] = '{r_dot ? K_FLOAT : K_INT, clip(r_soff), clip(open_len),
                                 clip(r_sline), clip(r_scol), 1'b0};
                    n = 2'd1; again = 1'b1;
                end
            end
            M_STRING: begin
                if (i_byte == (r_dq ? 8'h22 : 8'h27)) begin
                    o_tok[0] = '{K_STRING, clip(r_soff), clip(open_len), clip(r_sline),
                                 clip(r_scol), 1'b0};
                    n = 2'd1; n_mode = M_IDLE;
                end else if (i_byte == 8'h5C) n_mode = M_ESCAPE;
            end
            M_ESCAPE: n_mode = M_STRING;
            M_HOLD: begin
                if (r_held == 8'h2D && i_byte == 8'h2D) n_mode = M_LINE;
                else if (r_held == 8'h2D && c_digit) begin
                    n_dot = 1'b0; n_mode = M_NUMBER;
                end else if (r_held == 8'h2F && i_byte == 8'h2A) n_mode = M_BLOCK;
                else if (i_byte == 8'h3D && r_held != 8'h2D && r_held != 8'h2F) begin
                    k = (r_held == 8'h3D) ? K_EQ : (r_held == 8'h21) ? K_NE :
                        (r_held == 8'h3C) ? K_LE : K_GE;
                    o_tok[0] = '{k, clip(r_soff), 16'd2, clip(r_sline), clip(r_scol), 1'b0};
                    n = 2'd1; n_mode = M_IDLE;
                end else begin
                    o_tok[0] = '{held_kind(r_held), clip(r_soff), 16'd1, clip(r_sline),
                                 clip(r_scol), 1'b0};
                    n = 2'd1; again = 1'b1;
                end
            end
            M_LINE:  if (i_byte == 8'h0A) n_mode = M_IDLE;
            M_BLOCK: if (i_byte == 8'h2A) n_mode = M_STAR;
            M_STAR: begin
                if (i_byte == 8'h2F) n_mode = M_IDLE;
                else if (i_byte != 8'h2A) n_mode = M_BLOCK;
            end
            default: again = 1'b1;
        endcase

        // Byte seen from idle.
        if (again) begin
            n_mode = M_IDLE;
            if (c_ws) begin
            end else if (c_alpha) begin
                n_soff = r_off; n_sline = r_line; n_scol = r_col;
                n_word = {56'd0, c_up}; n_long = 1'b0; n_mode = M_IDENT;
            end else if (c_digit) begin
                n_soff = r_off; n_sline = r_line; n_scol = r_col;
                n_dot = 1'b0; n_mode = M_NUMBER;
            end else if (i_byte == 8'h27 || i_byte == 8'h22) begin
                n_dq = i_byte == 8'h22; n_mode = M_STRING; start_after = 1'b1;
            end else if (i_byte == 8'h2D || i_byte == 8'h2F || i_byte == 8'h3D ||
                         i_byte == 8'h21 || i_byte == 8'h3C || i_byte == 8'h3E) begin
                n_soff = r_off; n_sline = r_line; n_scol = r_col;
                n_held = i_byte; n_mode = M_HOLD;
            end else begin
                case (i_byte)
                    8'h3B:   k = K_SEMI;
                    8'h2C:   k = K_COMMA;
                    8'h28:   k = K_LPAREN;
                    8'h29:   k = K_RPAREN;
                    8'h2A:   k = K_MUL;
                    8'h2E:   k = K_DOT;
                    default: k = K_UNKNOWN;
                endcase
                o_tok[n] = '{k, clip(r_off), 16'd1, clip(r_line), clip(r_col), 1'b0};
                n = n + 2'd1;
            end
        end

        // Advance position counters.
        n_off = sinc(r_off);
        if (i_byte == 8'h0A) begin
            n_line = sinc(r_line); n_col = t_pos'(1);
        end else begin
            n_line = r_line; n_col = sinc(r_col);
        end
        if (start_after) begin
            n_soff = n_off; n_sline = n_line; n_scol = n_col;
        end

        // Flush on the last byte, then the end token, then return to reset.
        if (i_last) begin
            unique case (n_mode)
                M_IDENT: begin
                    o_tok[n] = '{n_long ? K_IDENT : kw_lookup(n_word), clip(n_soff),
                                 clip(n_off - n_soff), clip(n_sline), clip(n_scol), 1'b0};
                    n = n + 2'd1;
                end
                M_NUMBER: begin
                    o_tok[n] = '{n_dot ? K_FLOAT : K_INT, clip(n_soff),
                                 clip(n_off - n_soff), clip(n_sline), clip(n_scol), 1'b0};
                    n = n + 2'd1;
                end
                M_STRING, M_ESCAPE: begin
                    o_tok[n] = '{K_STRING, clip(n_soff), clip(n_off - n_soff),
                                 clip(n_sline), clip(n_scol), 1'b0};
                    n = n + 2'd1;
                end
                M_HOLD: begin
                    o_tok[n] = '{held_kind(n_held), clip(n_soff), 16'd1, clip(n_sline),
                                 clip(n_scol), 1'b0};
                    n = n + 2'd1;
                end
                default: begin
                end
            endcase
            o_tok[n] = '{K_END, clip(n_off), 16'd0, clip(n_line), clip(n_col), 1'b1};
            n = n + 2'd1;
            n_mode = M_IDLE; n_held = '0; n_word = '0; n_long = 1'b0; n_dot = 1'b0;
            n_dq = 1'b0; n_soff = '0; n_sline = t_pos'(1); n_scol = t_pos'(1);
            n_off = '0; n_line = t_pos'(1); n_col = t_pos'(1);
        end
        o_count = n;
    end

    // Hold state between bytes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE; r_held <= '0; r_word <= '0; r_long <= 1'b0;
            r_dot <= 1'b0; r_dq <= 1'b0; r_soff <= '0; r_sline <= t_pos'(1);
            r_scol <= t_pos'(1); r_off <= '0; r_line <= t_pos'(1); r_col <= t_pos'(1);
        end else if (i_en) begin
            r_mode <= n_mode; r_held <= n_held; r_word <= n_word; r_long <= n_long;
            r_dot <= n_dot; r_dq <= n_dq; r_soff <= n_soff; r_sline <= n_sline;
            r_scol <= n_scol; r_off <= n_off; r_line <= n_line; r_col <= n_col;
        end
    end

endmodule

### rtl/core/sts_checker.sv
// Port-level checks for the SQL token scanner and the bind that attaches
// them. Depends on sql_token_scanner.
module sts_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    // A stalled token holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled token changed");

    // The end token is kind end with zero length.
    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[5:0] == 6'd0 &&
        m_axis_tdata[37:22] == 16'd0)
        else $error("bad end token");

    // Line and column never zero on a token.
    a_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[53:38] != 16'd0 && m_axis_tdata[69:54] != 16'd0)
        else $error("zero line or column");

    // No token out of an empty scanner after reset.
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("token after reset");
endmodule

bind sql_token_scanner sts_checker u_sts_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);

### test/sql_token_scanner_tb.sv
// Testbench for sql_token_scanner: drives SQL source bytes and checks tokens
// against an in-bench lexer model through a small scoreboard class.
// Depends on sts_pkg and the scanner RTL.
module sql_token_scanner_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sts_pkg::*;

    localparam int POS_MAX = 65535;

    // Token store and mismatch count live here
    class token_board;
        t_token pending[$];
        int errors;

        // Report one mismatch
        task report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        // Note an expected token from the lexer model
        function void note(t_token t);
            pending.insert(pending.size(), t);
        endfunction

        // Compare an observed token with the oldest expectation
        task check(t_token got);
            t_token exp;
            if (pending.size() == 0) begin
                report($sformatf("unexpected token kind %0d", got.kind));
                return;
            end
            exp = pending.pop_front();
            if (got.kind !== exp.kind)
                report($sformatf("kind %0d exp %0d", got.kind, exp.kind));
            if (got.offset !== exp.offset)
                report($sformatf("offset %0d exp %0d", got.offset, exp.offset));
            if (got.length !== exp.length)
                report($sformatf("length %0d exp %0d", got.length, exp.length));
            if (got.line !== exp.line)
                report($sformatf("line %0d exp %0d", got.line, exp.line));
            if (got.column !== exp.column)
                report($sformatf("column %0d exp %0d", got.column, exp.column));
            if (got.fin !== exp.fin)
                report($sformatf("fin %0d exp %0d", got.fin, exp.fin));
        endtask
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 0;
    logic        s_axis_tlast = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [71:0] m_axis_tdata;
    logic        m_axis_tlast;

    sql_token_scanner uut (.*);

    always #5 i_clk = ~i_clk;

    token_board board = new();

    // Lexer model state
    t_mode     lx_mode;
    logic [7:0] lx_held;
    t_word     lx_word;
    bit        lx_long, lx_dot, lx_dq;
    int        tk_off, tk_line, tk_col, cur_off, cur_line, cur_col;

    function automatic int sat(int v);
        return v >= POS_MAX ? POS_MAX : v + 1;
    endfunction

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [7:0] up(logic [7:0] c);
        return (c >= "a" && c <= "z") ? c - 8'd32 : c;
    endfunction

    task automatic lx_reset();
        lx_mode = M_IDLE; lx_held = 0; lx_word = 0; lx_long = 0; lx_dot = 0; lx_dq = 0;
        tk_off = 0; tk_line = 1; tk_col = 1; cur_off = 0; cur_line = 1; cur_col = 1;
    endtask

    task automatic put(logic [5:0] k, int off, int len, int ln, int col, bit fin);
        t_token t;
        t.kind = k; t.offset = off[15:0]; t.length = len[15:0];
        t.line = ln[15:0]; t.column = col[15:0]; t.fin = fin;
        board.note(t);
    endtask

    task automatic put_open(logic [5:0] k, int len);
        put(k, tk_off, len, tk_line, tk_col, 0);
    endtask

    // Keyword search written independently of the package lookup
    task automatic put_word();
        logic [5:0] k;
        k = K_IDENT;
        if (!lx_long)
            for (int i = KEYWORD_COUNT - 1; i >= 0; i--)
                if (KW_ROM[i] == lx_word) k = K_KEYWORD0 + 6'(i);
        put_open(k, cur_off - tk_off);
    endtask

    function automatic logic [5:0] held_kind();
        case (lx_held)
            "=": return K_EQ;
            "!": return K_NOT;
            "<": return K_LT;
            ">": return K_GT;
            default: return K_UNKNOWN;
        endcase
    endfunction

    task automatic mark();
        tk_off = cur_off; tk_line = cur_line; tk_col = cur_col;
    endtask

    // Advance the model by one source byte and queue its tokens
    task automatic scan_byte(logic [7:0] c, bit last);
        bit again, after;
        logic [5:0] k;
        again = 1; after = 0;
        while (again) begin
            again = 0;
            case (lx_mode)
                M_IDENT: begin
                    if (is_alpha(c) || is_digit(c)) begin
                        if (lx_word[63:56] != 0) lx_long = 1;
                        else lx_word = {lx_word[55:0], up(c)};
                    end else begin
                        put_word(); lx_mode = M_IDLE; again = 1;
                    end
                end
                M_NUMBER: begin
                    if (is_digit(c)) ;
                    else if (c == "." && !lx_dot) lx_dot = 1;
                    else begin
                        put_open(lx_dot ? K_FLOAT : K_INT, cur_off - tk_off);
                        lx_mode = M_IDLE; again = 1;
                    end
                end
                M_STRING: begin
                    if (c == (lx_dq ? 8'h22 : 8'h27)) begin
                        put_open(K_STRING, cur_off - tk_off); lx_mode = M_IDLE;
                    end else if (c == 8'h5C) lx_mode = M_ESCAPE;
                end
                M_ESCAPE: lx_mode = M_STRING;
                M_HOLD: begin
                    if (lx_held == "-" && c == "-") lx_mode = M_LINE;
                    else if (lx_held == "-" && is_digit(c)) begin
                        lx_dot = 0; lx_mode = M_NUMBER;
                    end else if (lx_held == "/" && c == "*") lx_mode = M_BLOCK;
                    else if (c == "=" && lx_held != "-" && lx_held != "/") begin
                        k = lx_held == "=" ? K_EQ : lx_held == "!" ? K_NE :
                            lx_held == "<" ? K_LE : K_GE;
                        put_open(k, 2); lx_mode = M_IDLE;
                    end else begin
                        put_open(held_kind(), 1); lx_mode = M_IDLE; again = 1;
                    end
                end
                M_LINE: if (c == 8'h0A) lx_mode = M_IDLE;
                M_BLOCK: if (c == "*") lx_mode = M_STAR;
                M_STAR: begin
                    if (c == "/") lx_mode = M_IDLE;
                    else if (c != "*") lx_mode = M_BLOCK;
                end
                default: begin
                    lx_mode = M_IDLE;
                    if (c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A) ;
                    else if (is_alpha(c)) begin
                        mark(); lx_word = {56'd0, up(c)}; lx_long = 0; lx_mode = M_IDENT;
                    end else if (is_digit(c)) begin
                        mark(); lx_dot = 0; lx_mode = M_NUMBER;
                    end else if (c == 8'h27 || c == 8'h22) begin
                        lx_dq = (c == 8'h22); lx_mode = M_STRING; after = 1;
                    end else if (c == "-" || c == "/" || c == "=" || c == "!" ||
                                 c == "<" || c == ">") begin
                        mark(); lx_held = c; lx_mode = M_HOLD;
                    end else begin
                        case (c)
                            ";": k = K_SEMI;
                            ",": k = K_COMMA;
                            "(": k = K_LPAREN;
                            ")": k = K_RPAREN;
                            "*": k = K_MUL;
                            ".": k = K_DOT;
                            default: k = K_UNKNOWN;
                        endcase
                        put(k, cur_off, 1, cur_line, cur_col, 0);
                    end
                end
            endcase
        end
        cur_off = sat(cur_off);
        if (c == 8'h0A) begin
            cur_line = sat(cur_line); cur_col = 1;
        end else cur_col = sat(cur_col);
        if (after) mark();
        if (last) begin
            case (lx_mode)
                M_IDENT: put_word();
                M_NUMBER: put_open(lx_dot ? K_FLOAT : K_INT, cur_off - tk_off);
                M_STRING, M_ESCAPE: put_open(K_STRING, cur_off - tk_off);
                M_HOLD: put_open(held_kind(), 1);
                default: ;
            endcase
            put(K_END, cur_off, 0, cur_line, cur_col, 1);
            lx_reset();
        end
    endtask

    // Receiver stall pattern; a toggle of hold_req starts one long hold-off
    int  long_hold = 0;
    bit  hold_req = 0;
    bit  hold_ack = 0;
    bit  rx_quiet = 0;
    always @(posedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack <= hold_req;
            long_hold <= 200;
            m_axis_tready <= 0;
        end else if (long_hold > 0) begin
            long_hold <= long_hold - 1;
            m_axis_tready <= 0;
        end else if (rx_quiet)
            m_axis_tready <= 1;
        else
            m_axis_tready <= ($urandom_range(0, 3) != 0);
    end

    // Check every token request on the output side
    always @(posedge i_clk) begin
        t_token got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.kind = m_axis_tdata[5:0]; got.offset = m_axis_tdata[21:6];
            got.length = m_axis_tdata[37:22]; got.line = m_axis_tdata[53:38];
            got.column = m_axis_tdata[69:54]; got.fin = m_axis_tlast;
            board.check(got);
        end
    end

    // Watchdog on cycles without any request
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    int         burst = 0;

    // Offer one byte, holding valid until accepted
    task automatic send_byte(logic [7:0] c, bit last);
        int gap;
        if (burst == 0) begin
            gap = $urandom_range(0, 4);
            if (gap != 0) begin
                s_axis_tvalid <= 0;
                repeat (gap) @(posedge i_clk);
            end
            burst = $urandom_range(1, 12);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        scan_byte(c, last);
        burst--;
    endtask

    task automatic send_text(string s, bit last);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], last && (i == s.len() - 1));
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        burst = 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    string pieces[] = '{"SELECT", "distinct", "From", "x_1", "verylongname", "42",
        "3.14", "1.2.3", "-7", "'a\\'b'", "\"q\"", "<=", ">=", "!=", "==", "!",
        "<", ">", "=", "-", "/", ";", ",", "(", ")", "*", ".", "-- c\n",
        "/* b **/", " ", "\n", "\t", "\r", "desc", "between", "@"};

    initial begin
        string s;
        lx_reset();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: keywords, operators, comments, lone slash, unterminated cases
        send_text("SELECT a FROM t WHERE x<=-5.2;", 1);
        send_text("/*c*//*d*/-- e\ni!=1.2.3 ! >= /\n", 1);
        send_text("'ab\\", 1);
        send_text("DISTINCTLY ", 0);
        send_byte(8'h80, 0);
        send_byte(8'h00, 0);
        send_byte(8'hFF, 1);
        send_text("/* open", 1);
        drain();

        // Long receiver hold-off while the sender keeps offering bytes
        hold_req = ~hold_req;
        send_text("a;b;c;d;e;f;", 1);
        drain();

        // Random part: mostly well-formed fragments, some raw noise
        for (int n = 0; n < 12; ) begin
            if ($urandom_range(0, 4) == 0) begin
                send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
                n++;
            end else begin
                s = pieces[$urandom_range(0, pieces.size() - 1)];
                send_text(s, $urandom_range(0, 9) == 0);
                n += s.len();
            end
        end
        send_byte(" ", 1);
        drain();

        rx_quiet = 1;
        if (board.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
